/* design/bap_pkg.sv */
// Shared constants for the antialiased cubic Bezier plotter.
// No dependencies; every design file imports this package.
package bap_pkg;

   // Default geometry: pixel coordinate bits and curve fraction bits.
   localparam int COORD_BITS_DEF = 10;
   localparam int FRAC_BITS_DEF  = 16;

   // Curve parameter 1.0 in Q1.16.
   localparam logic [16:0] T_ONE = 17'h10000;

   // Full intensity and its square, used as the shading scale.
   localparam logic [7:0]  SHADE_FULL  = 8'd255;
   localparam logic [15:0] SHADE_SCALE = 16'd65025;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_P0_X = 3'd0;
   localparam logic [2:0] REG_P0_Y = 3'd1;
   localparam logic [2:0] REG_P1_X = 3'd2;
   localparam logic [2:0] REG_P1_Y = 3'd3;
   localparam logic [2:0] REG_P2_X = 3'd4;
   localparam logic [2:0] REG_P2_Y = 3'd5;
   localparam logic [2:0] REG_P3_X = 3'd6;
   localparam logic [2:0] REG_P3_Y = 3'd7;

   // Result beats of one curve parameter, in output order.
   localparam logic [2:0] BEAT_CENTER = 3'd0;
   localparam logic [2:0] BEAT_NB0    = 3'd1;
   localparam logic [2:0] BEAT_NB1    = 3'd2;
   localparam logic [2:0] BEAT_NB2    = 3'd3;
   localparam logic [2:0] BEAT_NB3    = 3'd4;

   // Shading runs one result bit per step, most significant first.
   localparam logic [2:0] SHADE_TOP_BIT = 3'd7;

endpackage

/* design/bezier_antialiased_plotter.sv */
// Top level of the antialiased cubic Bezier plotter: control point registers,
// front pipeline, queue and pixel sequencer. Depends on bap_pkg and submodules.
//
//   Channel  Ports                               Beat
//   req      req_valid/req_ready, req_t          one curve parameter t
//   rsp      rsp_valid/rsp_ready, rsp_pixel_*    one pixel write, five per t
//   csr      csr_write, csr_index, csr_wdata     one control point coordinate
//
// A t passes the front pipeline registers (three lerp levels, offsets, squares) and
// waits in a two-entry queue. The sequencer loads one entry, runs eight shading
// steps (one intensity bit each) and four neighbor beats before it takes the next one.
// Reset is synchronous and clears control state; control points reset to zero.
// A stalled rsp holds the sequencer, then the queue, then req_ready.
module bezier_antialiased_plotter
   import bap_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [16:0]                  req_t,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COORD_BITS:0]   rsp_pixel_x,
   output logic signed [COORD_BITS:0]   rsp_pixel_y,
   output logic [7:0]                   rsp_intensity,
   output logic                         rsp_last,
   input  logic                         csr_write,
   input  logic [2:0]                   csr_index,
   input  logic [COORD_BITS-1:0]        csr_wdata
);

   localparam int DS = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
   localparam int OB = FRAC_BITS + 1 - DS;
   localparam int SB = 2 * OB + 1;
   localparam int DW = 2 * COORD_BITS + 2 * (COORD_BITS + 1) + 4 * SB + SB + 16;

   logic [COORD_BITS-1:0] pt_x_ff [4], pt_y_ff [4];

   // Control point registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            pt_x_ff[i] <= '0;
            pt_y_ff[i] <= '0;
         end
      end else if (csr_write) begin
         case (csr_index)
            REG_P0_X: pt_x_ff[0] <= csr_wdata;
            REG_P0_Y: pt_y_ff[0] <= csr_wdata;
            REG_P1_X: pt_x_ff[1] <= csr_wdata;
            REG_P1_Y: pt_y_ff[1] <= csr_wdata;
            REG_P2_X: pt_x_ff[2] <= csr_wdata;
            REG_P2_Y: pt_y_ff[2] <= csr_wdata;
            REG_P3_X: pt_x_ff[3] <= csr_wdata;
            REG_P3_Y: pt_y_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic          f_valid, f_ready, b_valid, b_ready;
   logic [DW-1:0] f_data, b_data;
   logic [COORD_BITS:0] ox, oy;

   bap_front #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_t    (req_t),
      .pt_x     (pt_x_ff),
      .pt_y     (pt_y_ff),
      .q_valid  (f_valid),
      .q_ready  (f_ready),
      .q_data   (f_data)
   );

   bap_queue #(
      .DW(DW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(f_valid),
      .push_ready(f_ready),
      .push_data (f_data),
      .pop_valid (b_valid),
      .pop_ready (b_ready),
      .pop_data  (b_data)
   );

   bap_back #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (b_valid),
      .q_ready      (b_ready),
      .q_data       (b_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .out_x        (ox),
      .out_y        (oy),
      .out_intensity(rsp_intensity),
      .out_last     (rsp_last)
   );

   assign rsp_pixel_x = $signed(ox);
   assign rsp_pixel_y = $signed(oy);

endmodule

/* design/bap_queue.sv */
// Two-entry queue between the front pipeline and the pixel sequencer.
// Depends on bap_pkg only through the common import convention.
module bap_queue
   import bap_pkg::*;
#(
   parameter int DW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  logic [DW-1:0] push_data,
   output logic          pop_valid,
   input  logic          pop_ready,
   output logic [DW-1:0] pop_data
);

   logic [DW-1:0] mem_ff [2];
   logic          wr_ptr_ff, rd_ptr_ff;
   logic [1:0]    count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Occupancy follows pushes and pops.
   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 2'd1;
      else if (!do_push && do_pop) count_in = count_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (do_push) wr_ptr_ff <= ~wr_ptr_ff;
         if (do_pop) rd_ptr_ff <= ~rd_ptr_ff;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

/* design/bap_front.sv */
// Front pipeline: accepts t, runs de Casteljau in three lerp stages, then forms
// pixel positions and squared neighbor distances. Depends on bap_pkg.
module bap_front
   import bap_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [16:0]           req_t,
   input  logic [COORD_BITS-1:0] pt_x [4],
   input  logic [COORD_BITS-1:0] pt_y [4],
   output logic                  q_valid,
   input  logic                  q_ready,
   output logic [2*COORD_BITS+2*(COORD_BITS+1)+4*(2*(FRAC_BITS+1-
                 ((FRAC_BITS>16)?FRAC_BITS-16:0))+1)+
                 (2*(FRAC_BITS+1-((FRAC_BITS>16)?FRAC_BITS-16:0))+1)+16-1:0] q_data
);

   localparam int C   = COORD_BITS;
   localparam int F   = FRAC_BITS;
   localparam int W   = C + F;
   localparam int DS  = (F > 16) ? F - 16 : 0;
   localparam int OB  = F + 1 - DS;
   localparam int SB  = 2 * OB + 1;
   localparam int THW = SB + 16;
   localparam logic [W:0]          HALF  = (W+1)'(1) << (F - 1);
   localparam logic signed [W+1:0] ONE_S = (W+2)'(1) << F;

   // One linear interpolation: a + floor((b - a) * t / 65536).
   function automatic logic [W-1:0] lerp(input logic [W-1:0] a,
                                         input logic [W-1:0] b,
                                         input logic [16:0]  t);
      logic signed [W:0]    d;
      logic signed [W+18:0] p;
      d = $signed({1'b0, b}) - $signed({1'b0, a});
      p = d * $signed({1'b0, t});
      return a + p[W+15:16];
   endfunction

   logic        adv;
   logic [16:0] ts;
   logic        v1_ff, v2_ff, v3_ff, vd_ff, vq_ff;
   logic [16:0] t1_ff, t2_ff;
   logic [W-1:0] l1x_ff [3], l1y_ff [3], l2x_ff [2], l2y_ff [2];
   logic [W-1:0] l3x_ff, l3y_ff;
   logic [W-1:0] cx [4], cy [4];

   // The whole pipeline moves unless its last stage holds a beat the queue refuses.
   assign adv       = !vq_ff || q_ready;
   assign req_ready = adv;
   assign q_valid   = vq_ff;
   assign ts        = (req_t > T_ONE) ? T_ONE : req_t;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         cx[i] = {pt_x[i], {F{1'b0}}};
         cy[i] = {pt_y[i], {F{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vd_ff <= 1'b0;
         vq_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         vd_ff <= v3_ff;
         vq_ff <= vd_ff;
      end
   end

   // Three de Casteljau levels, one per stage.
   always_ff @(posedge clock) begin
      if (adv) begin
         t1_ff <= ts;
         t2_ff <= t1_ff;
         for (int i = 0; i < 3; i++) begin
            l1x_ff[i] <= lerp(cx[i], cx[i+1], ts);
            l1y_ff[i] <= lerp(cy[i], cy[i+1], ts);
         end
         for (int i = 0; i < 2; i++) begin
            l2x_ff[i] <= lerp(l1x_ff[i], l1x_ff[i+1], t1_ff);
            l2y_ff[i] <= lerp(l1y_ff[i], l1y_ff[i+1], t1_ff);
         end
         l3x_ff <= lerp(l2x_ff[0], l2x_ff[1], t2_ff);
         l3y_ff <= lerp(l2y_ff[0], l2y_ff[1], t2_ff);
      end
   end

   // Pixel positions and absolute offsets to the rounded pixel and its lower neighbor.
   logic [W:0]          xs, ys;
   logic [C:0]          hx, hy;
   logic signed [W+1:0] ex, ey, ax0w, ax1w, ay0w, ay1w;
   logic [C-1:0]        pxd_ff, pyd_ff, pxq_ff, pyq_ff;
   logic [C:0]          hxd_ff, hyd_ff, hxq_ff, hyq_ff;
   logic [OB-1:0]       ax0_ff, ax1_ff, ay0_ff, ay1_ff;

   always_comb begin
      xs   = {1'b0, l3x_ff} + HALF;
      ys   = {1'b0, l3y_ff} + HALF;
      hx   = xs[W:F];
      hy   = ys[W:F];
      ex   = $signed({1'b0, hx, {F{1'b0}}}) - $signed({2'b00, l3x_ff});
      ey   = $signed({1'b0, hy, {F{1'b0}}}) - $signed({2'b00, l3y_ff});
      ax0w = ex[W+1] ? -ex : ex;
      ay0w = ey[W+1] ? -ey : ey;
      ax1w = ONE_S - ex;
      ay1w = ONE_S - ey;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pxd_ff <= l3x_ff[W-1:F];
         pyd_ff <= l3y_ff[W-1:F];
         hxd_ff <= hx;
         hyd_ff <= hy;
         ax0_ff <= ax0w[F:DS];
         ax1_ff <= ax1w[F:DS];
         ay0_ff <= ay0w[F:DS];
         ay1_ff <= ay1w[F:DS];
      end
   end

   // Squared offsets.
   logic [2*OB-1:0] sx0_ff, sx1_ff, sy0_ff, sy1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         pxq_ff <= pxd_ff;
         pyq_ff <= pyd_ff;
         hxq_ff <= hxd_ff;
         hyq_ff <= hyd_ff;
         sx0_ff <= ax0_ff * ax0_ff;
         sx1_ff <= ax1_ff * ax1_ff;
         sy0_ff <= ay0_ff * ay0_ff;
         sy1_ff <= ay1_ff * ay1_ff;
      end
   end

   // Squared distances and the scaled center distance go into the queue entry.
   logic [SB-1:0]  s0, s1, s2, s3;
   logic [THW-1:0] thr;

   always_comb begin
      s0  = {1'b0, sx0_ff} + {1'b0, sy0_ff};
      s1  = {1'b0, sx0_ff} + {1'b0, sy1_ff};
      s2  = {1'b0, sx1_ff} + {1'b0, sy0_ff};
      s3  = {1'b0, sx1_ff} + {1'b0, sy1_ff};
      thr = {16'd0, s0} * {{SB{1'b0}}, SHADE_SCALE};
   end

   assign q_data = {pxq_ff, pyq_ff, hxq_ff, hyq_ff, s0, s1, s2, s3, thr};

endmodule

/* design/bap_back.sv */
// Pixel sequencer: takes one queue entry, shades the four neighbors one result
// bit per cycle in parallel, and sends the five pixel beats. Depends on bap_pkg.
module bap_back
   import bap_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_ready,
   input  logic [2*COORD_BITS+2*(COORD_BITS+1)+4*(2*(FRAC_BITS+1-
                 ((FRAC_BITS>16)?FRAC_BITS-16:0))+1)+
                 (2*(FRAC_BITS+1-((FRAC_BITS>16)?FRAC_BITS-16:0))+1)+16-1:0] q_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COORD_BITS:0]   out_x,
   output logic [COORD_BITS:0]   out_y,
   output logic [7:0]            out_intensity,
   output logic                  out_last
);

   localparam int C   = COORD_BITS;
   localparam int F   = FRAC_BITS;
   localparam int DS  = (F > 16) ? F - 16 : 0;
   localparam int OB  = F + 1 - DS;
   localparam int SB  = 2 * OB + 1;
   localparam int THW = SB + 16;

   logic [C-1:0]   qpx, qpy;
   logic [C:0]     qhx, qhy;
   logic [SB-1:0]  qs [4];
   logic [THW-1:0] qthr;

   assign {qpx, qpy, qhx, qhy, qs[0], qs[1], qs[2], qs[3], qthr} = q_data;

   logic           busy_ff, shading_ff;
   logic [2:0]     bit_ff, beat_ff;
   logic [C-1:0]   px_ff, py_ff;
   logic [C:0]     hx_ff, hy_ff;
   logic [THW-1:0] thr_ff;
   logic [THW-1:0] acc_ff [4], tac_ff [4], sq_ff [4];
   logic [7:0]     n_ff [4];
   logic           load, emit, out_free;
   logic           rsp_valid_ff;
   logic [C:0]     rx_ff, ry_ff, rx_in, ry_in;
   logic [7:0]     ri_ff, ri_in;
   logic           rl_ff, rl_in;

   assign q_ready  = !busy_ff;
   assign load     = q_valid && !busy_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;
   // The center beat goes out while shading runs; neighbor beats wait for it.
   assign emit     = busy_ff && out_free && ((beat_ff == BEAT_CENTER) || !shading_ff);

   // Sequencer control.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         shading_ff <= 1'b0;
         bit_ff     <= SHADE_TOP_BIT;
         beat_ff    <= BEAT_CENTER;
      end else if (load) begin
         busy_ff    <= 1'b1;
         shading_ff <= 1'b1;
         bit_ff     <= SHADE_TOP_BIT;
         beat_ff    <= BEAT_CENTER;
      end else begin
         if (shading_ff) begin
            if (bit_ff == 3'd0) shading_ff <= 1'b0;
            else bit_ff <= bit_ff - 3'd1;
         end
         if (emit) begin
            beat_ff <= beat_ff + 3'd1;
            if (beat_ff == BEAT_NB3) busy_ff <= 1'b0;
         end
      end
   end

   // Shading units: n is the largest value with n*n*sk <= 65025*s0. acc holds
   // n*n*sk, tac holds n*sk shifted by bit+1, and sq holds sk shifted by 2*bit.
   logic [THW-1:0] cand [4];

   always_comb begin
      for (int k = 0; k < 4; k++) cand[k] = acc_ff[k] + tac_ff[k] + sq_ff[k];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         px_ff  <= qpx;
         py_ff  <= qpy;
         hx_ff  <= qhx;
         hy_ff  <= qhy;
         thr_ff <= qthr;
         for (int k = 0; k < 4; k++) begin
            acc_ff[k] <= '0;
            tac_ff[k] <= '0;
            sq_ff[k]  <= THW'(qs[k]) << (2 * SHADE_TOP_BIT);
            n_ff[k]   <= 8'd0;
         end
      end else if (shading_ff) begin
         for (int k = 0; k < 4; k++) begin
            sq_ff[k] <= sq_ff[k] >> 2;
            if (cand[k] <= thr_ff) begin
               acc_ff[k] <= cand[k];
               tac_ff[k] <= (tac_ff[k] >> 1) + sq_ff[k];
               n_ff[k]   <= n_ff[k] | (8'd1 << bit_ff);
            end else begin
               tac_ff[k] <= tac_ff[k] >> 1;
            end
         end
      end
   end

   // Payload of the beat about to go out.
   always_comb begin
      rx_in = hx_ff;
      ry_in = hy_ff;
      ri_in = SHADE_FULL;
      rl_in = 1'b0;
      case (beat_ff)
         BEAT_CENTER: begin
            rx_in = {1'b0, px_ff};
            ry_in = {1'b0, py_ff};
         end
         BEAT_NB0: ri_in = n_ff[0];
         BEAT_NB1: begin
            ry_in = hy_ff - (C+1)'(1);
            ri_in = n_ff[1];
         end
         BEAT_NB2: begin
            rx_in = hx_ff - (C+1)'(1);
            ri_in = n_ff[2];
         end
         BEAT_NB3: begin
            rx_in = hx_ff - (C+1)'(1);
            ry_in = hy_ff - (C+1)'(1);
            ri_in = n_ff[3];
            rl_in = 1'b1;
         end
         default: ;
      endcase
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (emit) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rx_ff <= rx_in;
         ry_ff <= ry_in;
         ri_ff <= ri_in;
         rl_ff <= rl_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign out_x         = rx_ff;
   assign out_y         = ry_ff;
   assign out_intensity = ri_ff;
   assign out_last      = rl_ff;

endmodule

/* verif/bezier_antialiased_plotter_tb.sv */
// Testbench for the antialiased cubic Bezier plotter: drives curve parameters,
// predicts the five pixel writes of each one and checks them in order.
// Depends on bap_pkg and the bezier_antialiased_plotter design files.
`timescale 1ns / 1ps

module bezier_antialiased_plotter_tb;
   import bap_pkg::*;

   localparam int CB = COORD_BITS_DEF;
   localparam int FB = FRAC_BITS_DEF;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic signed [CB:0] px;
      logic signed [CB:0] py;
      logic [7:0]         inten;
      logic               last;
   } pixel_write_type;

   // Pending pixel writes and the curve predictor.
   class pixel_scoreboard_type;
      logic [CB-1:0]   ctrl_pt [8];
      pixel_write_type pending [$];
      int              mismatches;

      function void set_point(logic [2:0] idx, logic [CB-1:0] val);
         ctrl_pt[idx] = val;
      endfunction

      // Linear interpolation with the quotient rounded toward minus infinity.
      function longint lerp(longint a, longint b, longint t);
         longint prod;
         prod = (b - a) * t;
         if (prod >= 0) return a + (prod >>> 16);
         return a - ((-prod + 65535) >>> 16);
      endfunction

      function longint curve_axis(int axis, longint t);
         longint v [4];
         for (int i = 0; i < 4; i++) v[i] = longint'(ctrl_pt[2*i+axis]) <<< FB;
         for (int lvl = 3; lvl > 0; lvl--)
            for (int i = 0; i < lvl; i++) v[i] = lerp(v[i], v[i+1], t);
         return v[0];
      endfunction

      function longint sq_dist(longint px, longint py, longint x, longint y);
         longint dx, dy;
         dx = (px <<< FB) - x;
         dy = (py <<< FB) - y;
         if (dx < 0) dx = -dx;
         if (dy < 0) dy = -dy;
         return dx * dx + dy * dy;
      endfunction

      // Largest n with n*n*sk <= 65025*s0, built one bit at a time.
      function logic [7:0] shade(longint s0, longint sk);
         longint n, c;
         n = 0;
         if (sk == 0) return SHADE_FULL;
         for (int b = 7; b >= 0; b--) begin
            c = n | (longint'(1) << b);
            if (c * c * sk <= 65025 * s0) n = c;
         end
         return n[7:0];
      endfunction

      function void note_param(logic [16:0] t_in);
         longint t, x, y, hx, hy, s0;
         longint nx [4];
         longint ny [4];
         pixel_write_type w;
         t = (t_in > T_ONE) ? longint'(T_ONE) : longint'(t_in);
         x = curve_axis(0, t);
         y = curve_axis(1, t);
         w.px = (CB+1)'(x >>> FB);
         w.py = (CB+1)'(y >>> FB);
         w.inten = SHADE_FULL;
         w.last = 1'b0;
         pending = {pending, w};
         hx = (x + (longint'(1) <<< (FB-1))) >>> FB;
         hy = (y + (longint'(1) <<< (FB-1))) >>> FB;
         nx = '{hx, hx, hx-1, hx-1};
         ny = '{hy, hy-1, hy, hy-1};
         s0 = sq_dist(hx, hy, x, y);
         for (int k = 0; k < 4; k++) begin
            w.px = (CB+1)'(nx[k]);
            w.py = (CB+1)'(ny[k]);
            w.inten = shade(s0, sq_dist(nx[k], ny[k], x, y));
            w.last = (k == 3);
            pending = {pending, w};
         end
      endfunction

      function void check_write(pixel_write_type got);
         pixel_write_type exp_w;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected pixel write %p", got);
            return;
         end
         exp_w = pending.pop_front();
         if (got !== exp_w) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Pixel write mismatch: expected %p, got %p", exp_w, got);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [16:0] req_t = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [CB:0] rsp_pixel_x, rsp_pixel_y;
   logic [7:0] rsp_intensity;
   logic rsp_last;
   logic csr_write = 0;
   logic [2:0] csr_index = '0;
   logic [CB-1:0] csr_wdata = '0;

   pixel_scoreboard_type board = new();
   bit calm_phase = 0;
   bit hold_off = 0;
   int cycle_count = 0;
   int stall_left = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   bezier_antialiased_plotter DUT (.*);

   // Check every accepted result beat.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_write(pixel_write_type'{rsp_pixel_x, rsp_pixel_y,
                                             rsp_intensity, rsp_last});
   end

   // Receiver readiness: random stall bursts, a long hold-off on request,
   // none at the end.
   always @(posedge clock) begin
      if (hold_off) rsp_ready <= 0;
      else if (calm_phase) rsp_ready <= 1;
      else if (stall_left > 0) begin
         rsp_ready <= 0;
         stall_left = stall_left - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_ready <= 0;
         stall_left = $urandom_range(0, 7);
      end else rsp_ready <= 1;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic write_point(logic [2:0] idx, logic [CB-1:0] val);
      csr_write <= 1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      board.set_point(idx, val);
   endtask

   task automatic load_curve(int mode);
      logic [CB-1:0] v;
      for (int i = 0; i < 8; i++) begin
         case (mode)
            0: v = '0;
            1: v = '1;
            2: v = (i % 2 == 0) ? '1 : '0;
            3: v = (i < 4) ? '0 : '1;
            default: v = CB'($urandom_range(0, (1 << CB) - 1));
         endcase
         write_point(i[2:0], v);
      end
      csr_write <= 0;
   endtask

   // Offer one curve parameter, with an optional idle burst first.
   task automatic send_param(logic [16:0] t);
      if (!calm_phase && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1; req_t <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_param(t);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic logic [16:0] rand_param();
      case ($urandom_range(0, 9))
         0: return T_ONE;
         1: return 17'($urandom_range(65537, 131071));
         2: return 17'($urandom_range(0, 16));
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   initial begin
      logic [16:0] directed [10];
      directed = '{17'd0, 17'd1, 17'h8000, 17'hFFFF, T_ONE,
                   17'h10001, 17'h1FFFF, 17'h4000, 17'hC000, 17'h5555};
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: extreme curves and extreme parameters.
      for (int m = 0; m < 4; m++) begin
         load_curve(m);
         foreach (directed[i]) if (m == 2 || i < 5) send_param(directed[i]);
         drain();
      end

      // Random curves, with one long receiver hold-off in the middle.
      for (int ph = 0; ph < 8; ph++) begin
         load_curve(4);
         if (ph == 7) calm_phase = 1;
         if (ph == 3) begin
            fork
               begin
                  hold_off = 1;
                  repeat (200) @(posedge clock);
                  hold_off = 0;
               end
            join_none
         end
         for (int i = 0; i < 48; i++) send_param(rand_param());
         drain();
      end

      if (board.mismatches == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
